FILE: rtl/core/tnrx_pkg.sv
// ---------------------------------------------------------------------------
// tnrx_pkg: telnet receive-side option negotiator definitions
// Protocol codes, parser phases and the reply job record.
// ---------------------------------------------------------------------------
package tnrx_pkg;

  localparam int TYPE_MAX_BYTES_DEF = 40;

  // Telnet command bytes
  localparam logic [7:0] T_IAC  = 8'd255;
  localparam logic [7:0] T_DONT = 8'd254;
  localparam logic [7:0] T_DO   = 8'd253;
  localparam logic [7:0] T_WONT = 8'd252;
  localparam logic [7:0] T_WILL = 8'd251;
  localparam logic [7:0] T_SB   = 8'd250;
  localparam logic [7:0] T_SE   = 8'd240;

  // Options
  localparam logic [7:0] OPTION_ECHO  = 8'd1;
  localparam logic [7:0] OPTION_SGA   = 8'd3;
  localparam logic [7:0] OPTION_TTYPE = 8'd24;
  localparam logic [7:0] OPTION_NAWS  = 8'd31;

  localparam logic [7:0] TTYPE_IS  = 8'd0;

  // Window size defaults when the register holds zero
  localparam logic [15:0] DEF_COLUMNS = 16'd80;
  localparam logic [15:0] DEF_ROWS    = 16'd24;

  // Configuration register indexes
  localparam logic [3:0] REG_COLUMNS   = 4'd0;
  localparam logic [3:0] REG_ROWS      = 4'd1;
  localparam logic [3:0] REG_TYPE_LEN  = 4'd2;
  localparam logic [3:0] REG_TYPE_BASE = 4'd3;

  localparam logic [63:0] TYPE_WORD0_RESET = 64'h0000_006D_7265_7478; // "xterm"
  localparam logic [5:0]  TYPE_LEN_RESET   = 6'd5;

  // Pending verb: received command minus WILL
  localparam logic [1:0] VERB_WILL = 2'd0;
  localparam logic [1:0] VERB_WONT = 2'd1;
  localparam logic [1:0] VERB_DO   = 2'd2;
  localparam logic [1:0] VERB_DONT = 2'd3;

  typedef enum logic [2:0] {
    PH_DATA,
    PH_IAC,
    PH_OPTION,
    PH_SBFIRST,
    PH_SBBODY,
    PH_SBIAC
  } phase_t;

  typedef enum logic [1:0] {
    JOB_DATA,   // one byte to the terminal
    JOB_REPLY,  // IAC verb option
    JOB_NAWS,   // IAC WILL NAWS, then the window size subnegotiation
    JOB_TYPE    // terminal type subnegotiation
  } job_kind_t;

  typedef struct packed {
    job_kind_t  kind;
    logic [7:0] verb;
    logic [7:0] opt;
  } job_t;

endpackage

FILE: rtl/core/telnet_rx_option_negotiator_unit.sv
// ---------------------------------------------------------------------------
// telnet_rx_option_negotiator_unit: telnet receive-side option negotiator
// Parses server bytes, forwards data and answers option requests.
// ---------------------------------------------------------------------------
// Usage:
//  - s_axis: one server byte per transfer in tdata[7:0].
//  - m_axis: one result byte per transfer. tdata[7:0] is the byte, tuser is
//    the destination (0 terminal, 1 reply to server), tlast marks the final
//    result caused by one input byte.
//  - cfg: register writes (index, 64-bit data); always ready. Write only
//    while the block is idle.
// Timing:
//  - Each accepted byte is parsed in the accept cycle; the parser state and
//    a reply job are registered. The job walker then emits one byte per
//    cycle, while the output register is free, into that register, so the first
//    result passes the job register and then the output register to m_axis.
//  - Plain data bytes sustain one transfer per cycle while m_axis does not stall.
//    A byte that causes a reply burst holds the input off until its last byte
//    is emitted: 3 bytes for a plain answer, 12 to 16 for DO NAWS, 6 plus the
//    type length for a terminal type reply. Bytes with no result do not hold it.
// Reset clears the parser, the agreed flag and the output valid flag and
// loads the register defaults (80 x 24, "xterm"); no clearing pass.
// A stall on m_axis holds the output register; the walker and then the
// input side stop behind it, nothing is dropped.
// ---------------------------------------------------------------------------
module telnet_rx_option_negotiator_unit #(
  parameter int TYPE_MAX_BYTES = tnrx_pkg::TYPE_MAX_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tuser,   // [0] to_server
  output logic        m_axis_tlast,   // last_of_run
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int TypeWords = (TYPE_MAX_BYTES + 7) / 8;
  localparam int WordIdxW  = (TypeWords > 1) ? $clog2(TypeWords) : 1;
  localparam logic [5:0] TypeMax = 6'(TYPE_MAX_BYTES);

  // ---------------- configuration registers ----------------
  logic [15:0] window_columns;
  logic [15:0] window_rows;
  logic [5:0]  type_length;
  logic [63:0] type_word [TypeWords];

  logic        cfg_write;
  logic [3:0]  cfg_word;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid & cfg_ready;
  assign cfg_word  = cfg_index - tnrx_pkg::REG_TYPE_BASE;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_columns <= tnrx_pkg::DEF_COLUMNS;
      window_rows    <= tnrx_pkg::DEF_ROWS;
      type_length    <= tnrx_pkg::TYPE_LEN_RESET;
    end else if (cfg_write) begin
      if (cfg_index == tnrx_pkg::REG_COLUMNS) begin
        window_columns <= cfg_data[15:0];
      end
      if (cfg_index == tnrx_pkg::REG_ROWS) begin
        window_rows <= cfg_data[15:0];
      end
      if (cfg_index == tnrx_pkg::REG_TYPE_LEN) begin
        type_length <= cfg_data[5:0];
      end
    end
  end

  for (genvar w = 0; w < TypeWords; w++) begin : g_type
    always_ff @(posedge clk) begin
      if (rst) begin
        type_word[w] <= (w == 0) ? tnrx_pkg::TYPE_WORD0_RESET : 64'd0;
      end else if (cfg_write && cfg_index >= tnrx_pkg::REG_TYPE_BASE &&
                   cfg_word == 4'(w)) begin
        type_word[w] <= cfg_data;
      end
    end
  end

  // ---------------- parser ----------------
  tnrx_pkg::phase_t phase, phase_next;
  logic [1:0]       pending_verb, pending_verb_next;
  logic [7:0]       sub_option, sub_option_next;
  logic             ttype_agreed, ttype_agreed_next;

  tnrx_pkg::job_t   job, new_job;
  logic             job_valid, new_job_valid;
  logic [5:0]       idx, idx_next;

  logic             in_accept;
  logic             emit_fire;
  logic             job_last;
  logic [7:0]       rx;

  assign rx        = s_axis_tdata;
  assign in_accept = s_axis_tvalid & s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= tnrx_pkg::PH_DATA;
      pending_verb <= '0;
      sub_option   <= '0;
      ttype_agreed <= 1'b0;
    end else if (in_accept) begin
      phase        <= phase_next;
      pending_verb <= pending_verb_next;
      sub_option   <= sub_option_next;
      ttype_agreed <= ttype_agreed_next;
    end
  end

  always_comb begin
    phase_next        = phase;
    pending_verb_next = pending_verb;
    sub_option_next   = sub_option;
    ttype_agreed_next = ttype_agreed;
    new_job_valid     = 1'b0;
    new_job.kind      = tnrx_pkg::JOB_DATA;
    new_job.verb      = tnrx_pkg::T_WILL;
    new_job.opt       = rx;
    unique case (phase)
      tnrx_pkg::PH_DATA: begin
        if (rx == tnrx_pkg::T_IAC) begin
          phase_next = tnrx_pkg::PH_IAC;
        end else begin
          new_job_valid = 1'b1;
        end
      end
      tnrx_pkg::PH_IAC: begin
        priority if (rx == tnrx_pkg::T_IAC) begin
          new_job_valid = 1'b1;          // literal 0xFF to the terminal
          phase_next    = tnrx_pkg::PH_DATA;
        end else if (rx >= tnrx_pkg::T_WILL) begin
          pending_verb_next = 2'(rx - tnrx_pkg::T_WILL);
          phase_next        = tnrx_pkg::PH_OPTION;
        end else if (rx == tnrx_pkg::T_SB) begin
          phase_next = tnrx_pkg::PH_SBFIRST;
        end else begin
          phase_next = tnrx_pkg::PH_DATA; // other commands dropped
        end
      end
      tnrx_pkg::PH_OPTION: begin
        new_job_valid = 1'b1;
        new_job.kind  = tnrx_pkg::JOB_REPLY;
        phase_next    = tnrx_pkg::PH_DATA;
        unique case (pending_verb)
          tnrx_pkg::VERB_DO: begin
            priority if (rx == tnrx_pkg::OPTION_SGA) begin
              new_job.verb = tnrx_pkg::T_WILL;
            end else if (rx == tnrx_pkg::OPTION_TTYPE) begin
              new_job.verb      = tnrx_pkg::T_WILL;
              ttype_agreed_next = 1'b1;
            end else if (rx == tnrx_pkg::OPTION_NAWS) begin
              new_job.verb = tnrx_pkg::T_WILL;
              new_job.kind = tnrx_pkg::JOB_NAWS;
            end else begin
              new_job.verb = tnrx_pkg::T_WONT;
            end
          end
          tnrx_pkg::VERB_WILL: begin
            new_job.verb = (rx == tnrx_pkg::OPTION_ECHO || rx == tnrx_pkg::OPTION_SGA) ?
                           tnrx_pkg::T_DO : tnrx_pkg::T_DONT;
          end
          tnrx_pkg::VERB_DONT: begin
            if (rx == tnrx_pkg::OPTION_TTYPE) begin
              ttype_agreed_next = 1'b0;
            end
            new_job.verb = tnrx_pkg::T_WONT;
          end
          tnrx_pkg::VERB_WONT: begin
            new_job.verb = tnrx_pkg::T_DONT;
          end
        endcase
      end
      tnrx_pkg::PH_SBFIRST: begin
        sub_option_next = rx;
        phase_next = (rx == tnrx_pkg::T_IAC) ? tnrx_pkg::PH_SBIAC : tnrx_pkg::PH_SBBODY;
      end
      tnrx_pkg::PH_SBBODY: begin
        if (rx == tnrx_pkg::T_IAC) begin
          phase_next = tnrx_pkg::PH_SBIAC;
        end
      end
      tnrx_pkg::PH_SBIAC: begin
        priority if (rx == tnrx_pkg::T_SE) begin
          phase_next = tnrx_pkg::PH_DATA;
          if (sub_option == tnrx_pkg::OPTION_TTYPE && ttype_agreed) begin
            new_job_valid = 1'b1;
            new_job.kind  = tnrx_pkg::JOB_TYPE;
          end
        end else if (rx != tnrx_pkg::T_IAC) begin
          phase_next = tnrx_pkg::PH_SBBODY;
        end
      end
      default: begin
        phase_next = tnrx_pkg::PH_DATA;
      end
    endcase
  end

  // ---------------- job walker ----------------
  logic [15:0] cols_eff, rows_eff;
  logic [5:0]  type_count;    // saturated type length
  logic [5:0]  type_last;     // index of the closing SE
  logic [5:0]  naws_k;        // position within the window value slots
  logic [5:0]  type_i;        // type byte number
  logic [7:0]  naws_val;
  logic [63:0] type_sel;
  logic [7:0]  type_byte;
  logic [7:0]  emit_byte;
  logic        emit_server;

  assign cols_eff   = (window_columns == 16'd0) ? tnrx_pkg::DEF_COLUMNS : window_columns;
  assign rows_eff   = (window_rows == 16'd0) ? tnrx_pkg::DEF_ROWS : window_rows;
  assign type_count = (type_length > TypeMax) ? TypeMax : type_length;
  assign type_last  = type_count + 6'd5;
  assign naws_k     = idx - 6'd6;
  assign type_i     = idx - 6'd4;
  assign type_sel   = type_word[WordIdxW'(type_i >> 3)];
  assign type_byte  = type_sel[{type_i[2:0], 3'b000} +: 8];

  always_comb begin
    unique case (naws_k[2:1])
      2'd0: naws_val = cols_eff[15:8];
      2'd1: naws_val = cols_eff[7:0];
      2'd2: naws_val = rows_eff[15:8];
      2'd3: naws_val = rows_eff[7:0];
    endcase
  end

  always_comb begin
    emit_byte   = tnrx_pkg::T_IAC;
    emit_server = 1'b1;
    job_last    = 1'b0;
    idx_next    = idx + 6'd1;
    unique case (job.kind)
      tnrx_pkg::JOB_DATA: begin
        emit_byte   = job.opt;
        emit_server = 1'b0;
        job_last    = 1'b1;
      end
      tnrx_pkg::JOB_REPLY: begin
        priority if (idx == 6'd0) emit_byte = tnrx_pkg::T_IAC;
        else if (idx == 6'd1)     emit_byte = job.verb;
        else                      emit_byte = job.opt;
        job_last = (idx == 6'd2);
      end
      tnrx_pkg::JOB_NAWS: begin
        priority if (idx == 6'd0) emit_byte = tnrx_pkg::T_IAC;
        else if (idx == 6'd1)     emit_byte = job.verb;
        else if (idx == 6'd2)     emit_byte = job.opt;
        else if (idx == 6'd3)     emit_byte = tnrx_pkg::T_IAC;
        else if (idx == 6'd4)     emit_byte = tnrx_pkg::T_SB;
        else if (idx == 6'd5)     emit_byte = tnrx_pkg::OPTION_NAWS;
        else if (idx == 6'd14)    emit_byte = tnrx_pkg::T_IAC;
        else if (idx == 6'd15) begin
          emit_byte = tnrx_pkg::T_SE;
          job_last  = 1'b1;
        end else if (!naws_k[0] && naws_val != tnrx_pkg::T_IAC) begin
          emit_byte = naws_val;     // no escape needed, skip the value slot
          idx_next  = idx + 6'd2;
        end else if (!naws_k[0]) begin
          emit_byte = tnrx_pkg::T_IAC;
        end else begin
          emit_byte = naws_val;
        end
      end
      tnrx_pkg::JOB_TYPE: begin
        priority if (idx == 6'd0)     emit_byte = tnrx_pkg::T_IAC;
        else if (idx == 6'd1)         emit_byte = tnrx_pkg::T_SB;
        else if (idx == 6'd2)         emit_byte = tnrx_pkg::OPTION_TTYPE;
        else if (idx == 6'd3)         emit_byte = tnrx_pkg::TTYPE_IS;
        else if (idx == type_last) begin
          emit_byte = tnrx_pkg::T_SE;
          job_last  = 1'b1;
        end else if (idx == type_last - 6'd1) begin
          emit_byte = tnrx_pkg::T_IAC;
        end else begin
          emit_byte = type_byte;
        end
      end
    endcase
  end

  assign emit_fire     = job_valid & (~m_axis_tvalid | m_axis_tready);
  assign s_axis_tready = ~job_valid | (emit_fire & job_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      idx       <= '0;
    end else if (in_accept) begin
      job_valid <= new_job_valid;
      idx       <= '0;
    end else if (emit_fire) begin
      if (job_last) begin
        job_valid <= 1'b0;
      end else begin
        idx <= idx_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      job <= new_job;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (emit_fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      m_axis_tdata <= emit_byte;
      m_axis_tuser <= emit_server;
      m_axis_tlast <= job_last;
    end
  end

  // ---------------- assertions ----------------
  a_job_holds: assert property (@(posedge clk) disable iff (rst)
    (job_valid && !emit_fire) |=> (job_valid && $stable(idx)))
    else $error("job changed while stalled");

  a_job_done: assert property (@(posedge clk) disable iff (rst)
    (emit_fire && job_last && !in_accept) |=> !job_valid)
    else $error("job still pending after its last byte");

  a_naws_range: assert property (@(posedge clk) disable iff (rst)
    (job_valid && job.kind == tnrx_pkg::JOB_NAWS) |-> (idx <= 6'd15))
    else $error("window reply index out of range");

  a_term_single: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tlast)
    else $error("terminal byte not last of its run");

  a_agree_src: assert property (@(posedge clk) disable iff (rst)
    $rose(ttype_agreed) |-> $past(in_accept && phase == tnrx_pkg::PH_OPTION))
    else $error("type flag set outside option reply");

endmodule

FILE: tb/sv/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: telnet receive-side option negotiator regression
// Streams server bytes into the unit and mirrors its parser, option answers
// and window size / terminal type replies in a scoreboard class. Each output
// transfer is checked field by field, in order, against the mirrored bytes.
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT    = 500000;
  localparam int DRAIN_CYCLES   = 8;     // idle cycles after the last due byte, before register writes
  localparam int NUM_TYPE_WORDS = 5;
  localparam int ITEMS_PER_PART = 60;

  localparam logic [7:0] CMD_NOP = 8'd241;
  // indexes past the register list, written to show they are ignored
  localparam logic [3:0] REG_UNUSED_LO = 4'd8;
  localparam logic [3:0] REG_UNUSED_HI = 4'd15;

  typedef struct {
    logic [7:0] data;
    logic       to_server;
    logic       last;
  } out_byte_t;

  // -------------------------------------------------------------------------
  // Mirror of the negotiator: parser state, registers and the bytes still due
  // -------------------------------------------------------------------------
  class negotiator_mirror;
    logic [15:0]      columns;
    logic [15:0]      rows;
    logic [5:0]       type_len;
    logic [63:0]      type_words [NUM_TYPE_WORDS];
    tnrx_pkg::phase_t phase;
    logic [1:0]       verb;
    logic [7:0]       sub_opt;
    logic             ttype_agreed;
    out_byte_t        due_bytes [$];
    int               mismatches;

    function new();
      columns  = tnrx_pkg::DEF_COLUMNS;
      rows     = tnrx_pkg::DEF_ROWS;
      type_len = tnrx_pkg::TYPE_LEN_RESET;
      foreach (type_words[w]) type_words[w] = '0;
      type_words[0] = tnrx_pkg::TYPE_WORD0_RESET;
      phase        = tnrx_pkg::PH_DATA;
      verb         = tnrx_pkg::VERB_WILL;
      sub_opt      = '0;
      ttype_agreed = 1'b0;
      mismatches   = 0;
    endfunction

    function void push_out(logic [7:0] b, logic srv);
      out_byte_t o;
      o.data      = b;
      o.to_server = srv;
      o.last      = 1'b0;
      due_bytes.push_back(o);
    endfunction

    function void push_reply(logic [7:0] verb_code, logic [7:0] opt);
      push_out(tnrx_pkg::T_IAC, 1'b1);
      push_out(verb_code, 1'b1);
      push_out(opt, 1'b1);
    endfunction

    // window size bytes equal to IAC go out doubled
    function void push_escaped(logic [7:0] b);
      if (b == tnrx_pkg::T_IAC) push_out(tnrx_pkg::T_IAC, 1'b1);
      push_out(b, 1'b1);
    endfunction

    function void push_window();
      logic [15:0] c;
      logic [15:0] r;
      c = (columns == '0) ? tnrx_pkg::DEF_COLUMNS : columns;
      r = (rows == '0) ? tnrx_pkg::DEF_ROWS : rows;
      push_out(tnrx_pkg::T_IAC, 1'b1);
      push_out(tnrx_pkg::T_SB, 1'b1);
      push_out(tnrx_pkg::OPTION_NAWS, 1'b1);
      push_escaped(c[15:8]);
      push_escaped(c[7:0]);
      push_escaped(r[15:8]);
      push_escaped(r[7:0]);
      push_out(tnrx_pkg::T_IAC, 1'b1);
      push_out(tnrx_pkg::T_SE, 1'b1);
    endfunction

    // type string bytes are sent raw, length saturates at the string store size
    function void push_type();
      int n;
      n = (type_len > tnrx_pkg::TYPE_MAX_BYTES_DEF) ? tnrx_pkg::TYPE_MAX_BYTES_DEF : type_len;
      push_out(tnrx_pkg::T_IAC, 1'b1);
      push_out(tnrx_pkg::T_SB, 1'b1);
      push_out(tnrx_pkg::OPTION_TTYPE, 1'b1);
      push_out(tnrx_pkg::TTYPE_IS, 1'b1);
      for (int i = 0; i < n; i++) push_out(type_words[i >> 3][(i & 7) * 8 +: 8], 1'b1);
      push_out(tnrx_pkg::T_IAC, 1'b1);
      push_out(tnrx_pkg::T_SE, 1'b1);
    endfunction

    function void answer_option(logic [7:0] opt);
      case (verb)
        tnrx_pkg::VERB_DO: begin
          if (opt == tnrx_pkg::OPTION_SGA) begin
            push_reply(tnrx_pkg::T_WILL, opt);
          end else if (opt == tnrx_pkg::OPTION_TTYPE) begin
            ttype_agreed = 1'b1;
            push_reply(tnrx_pkg::T_WILL, opt);
          end else if (opt == tnrx_pkg::OPTION_NAWS) begin
            push_reply(tnrx_pkg::T_WILL, opt);
            push_window();
          end else begin
            push_reply(tnrx_pkg::T_WONT, opt);
          end
        end
        tnrx_pkg::VERB_WILL: begin
          if (opt == tnrx_pkg::OPTION_ECHO || opt == tnrx_pkg::OPTION_SGA)
            push_reply(tnrx_pkg::T_DO, opt);
          else push_reply(tnrx_pkg::T_DONT, opt);
        end
        tnrx_pkg::VERB_DONT: begin
          if (opt == tnrx_pkg::OPTION_TTYPE) ttype_agreed = 1'b0;
          push_reply(tnrx_pkg::T_WONT, opt);
        end
        default: begin
          push_reply(tnrx_pkg::T_DONT, opt);
        end
      endcase
    endfunction

    function void take_cfg_write(logic [3:0] idx, logic [63:0] value);
      if (idx == tnrx_pkg::REG_COLUMNS) columns = value[15:0];
      else if (idx == tnrx_pkg::REG_ROWS) rows = value[15:0];
      else if (idx == tnrx_pkg::REG_TYPE_LEN) type_len = value[5:0];
      else if (idx >= tnrx_pkg::REG_TYPE_BASE &&
               idx < tnrx_pkg::REG_TYPE_BASE + NUM_TYPE_WORDS)
        type_words[idx - tnrx_pkg::REG_TYPE_BASE] = value;
    endfunction

    function void take_rx_byte(logic [7:0] b);
      int first;
      first = due_bytes.size();
      case (phase)
        tnrx_pkg::PH_IAC: begin
          if (b == tnrx_pkg::T_IAC) begin
            push_out(tnrx_pkg::T_IAC, 1'b0);
            phase = tnrx_pkg::PH_DATA;
          end else if (b >= tnrx_pkg::T_WILL) begin
            verb  = 2'(b - tnrx_pkg::T_WILL);
            phase = tnrx_pkg::PH_OPTION;
          end else if (b == tnrx_pkg::T_SB) begin
            phase = tnrx_pkg::PH_SBFIRST;
          end else begin
            phase = tnrx_pkg::PH_DATA;
          end
        end
        tnrx_pkg::PH_OPTION: begin
          answer_option(b);
          phase = tnrx_pkg::PH_DATA;
        end
        tnrx_pkg::PH_SBFIRST: begin
          sub_opt = b;
          phase   = (b == tnrx_pkg::T_IAC) ? tnrx_pkg::PH_SBIAC : tnrx_pkg::PH_SBBODY;
        end
        tnrx_pkg::PH_SBBODY: begin
          if (b == tnrx_pkg::T_IAC) phase = tnrx_pkg::PH_SBIAC;
        end
        tnrx_pkg::PH_SBIAC: begin
          if (b == tnrx_pkg::T_SE) begin
            if (sub_opt == tnrx_pkg::OPTION_TTYPE && ttype_agreed) push_type();
            phase = tnrx_pkg::PH_DATA;
          end else if (b != tnrx_pkg::T_IAC) begin
            phase = tnrx_pkg::PH_SBBODY;
          end
        end
        default: begin
          if (b == tnrx_pkg::T_IAC) phase = tnrx_pkg::PH_IAC;
          else push_out(b, 1'b0);
        end
      endcase
      if (due_bytes.size() > first) due_bytes[$].last = 1'b1;
    endfunction

    function void match_out_byte(logic [7:0] data, logic to_server, logic last);
      out_byte_t want;
      if (due_bytes.size() == 0) begin
        $error("unexpected result: out_byte %02h to_server %0b last_of_run %0b",
               data, to_server, last);
        mismatches++;
        return;
      end
      want = due_bytes.pop_front();
      if (data !== want.data) begin
        $error("out_byte: expected %02h, got %02h", want.data, data);
        mismatches++;
      end
      if (to_server !== want.to_server) begin
        $error("to_server: expected %0b, got %0b", want.to_server, to_server);
        mismatches++;
      end
      if (last !== want.last) begin
        $error("last_of_run: expected %0b, got %0b", want.last, last);
        mismatches++;
      end
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // Clock, reset and DUT hookup; every input starts at a known value
  // -------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;   // [7:0] out_byte
  logic        m_axis_tuser;   // [0] to_server
  logic        m_axis_tlast;   // last_of_run
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  int send_gap_pct = 11;   // chance of an idle cycle before each input transfer
  int stall_pct    = 79;   // chance of the receiver holding tready low in a cycle
  int cycle_count  = 0;

  negotiator_mirror mirror = new();

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  telnet_rx_option_negotiator_unit dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Receiver backpressure: redrawn every cycle at the falling edge.
  always @(negedge clk) begin
    m_axis_tready = ($urandom_range(99) >= stall_pct);
  end

  // Output side: every completed transfer is checked at the rising edge.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      mirror.match_out_byte(m_axis_tdata, m_axis_tuser, m_axis_tlast);
  end

  // Watchdog: a hung handshake ends the run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("telnet_rx_option_negotiator_unit regression: fail");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Drivers: all start and end at a falling edge
  // -------------------------------------------------------------------------

  // One input transfer. tvalid stays high into the next call unless a gap is drawn.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_gap_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = b;
    do @(posedge clk); while (!s_axis_tready);
    mirror.take_rx_byte(b);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [3:0] idx, input logic [63:0] value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    mirror.take_cfg_write(idx, value);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Wait for every due byte, then let the parser settle before touching registers.
  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (mirror.due_bytes.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Mostly well-formed telnet sequences with random content, plus some noise.
  // Noise bytes do not count toward the target.
  task automatic run_random(input int target);
    int          sent;
    int          kind;
    int          n;
    logic [7:0]  b;
    sent = 0;
    while (sent < target) begin
      kind = $urandom_range(99);
      if (kind < 30) begin
        // plain data, anything but IAC
        send_byte(8'($urandom_range(254)));
        sent++;
      end else if (kind < 36) begin
        // escaped 0xFF
        send_byte(tnrx_pkg::T_IAC);
        send_byte(tnrx_pkg::T_IAC);
        sent += 2;
      end else if (kind < 42) begin
        // other command after IAC (SE, NOP, GA, ...) is dropped
        send_byte(tnrx_pkg::T_IAC);
        send_byte(8'($urandom_range(249)));
        sent += 2;
      end else if (kind < 75) begin
        // option request, biased toward the options that get accepted
        send_byte(tnrx_pkg::T_IAC);
        send_byte(tnrx_pkg::T_WILL + 8'($urandom_range(3)));
        case ($urandom_range(4))
          0:       b = tnrx_pkg::OPTION_ECHO;
          1:       b = tnrx_pkg::OPTION_SGA;
          2:       b = tnrx_pkg::OPTION_TTYPE;
          3:       b = tnrx_pkg::OPTION_NAWS;
          default: b = 8'($urandom);
        endcase
        send_byte(b);
        sent += 3;
      end else if (kind < 92) begin
        // subnegotiation; first byte may be IAC, body may hold stray IACs
        send_byte(tnrx_pkg::T_IAC);
        send_byte(tnrx_pkg::T_SB);
        n = $urandom_range(99);
        b = (n < 60) ? tnrx_pkg::OPTION_TTYPE : (n < 75) ? tnrx_pkg::T_IAC : 8'($urandom);
        send_byte(b);
        n = $urandom_range(4);
        repeat (n) send_byte(8'($urandom));
        send_byte(tnrx_pkg::T_IAC);
        send_byte(tnrx_pkg::T_SE);
        sent += 5 + n;
      end else begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
      end
    end
    s_axis_tvalid = 1'b0;
  endtask

  // -------------------------------------------------------------------------
  // Test sequence
  // -------------------------------------------------------------------------
  initial begin
    logic [7:0] directed_seq [$];

    // data extremes, escaped IAC, a dropped command, TTYPE agreement and a
    // TTYPE request whose body has IAC + data and a doubled IAC before SE,
    // NAWS with reset window size, WILL/WONT/DONT answers
    directed_seq = '{8'h00, 8'hFE,
                     tnrx_pkg::T_IAC, tnrx_pkg::T_IAC,
                     tnrx_pkg::T_IAC, CMD_NOP,
                     tnrx_pkg::T_IAC, tnrx_pkg::T_DO, tnrx_pkg::OPTION_TTYPE,
                     tnrx_pkg::T_IAC, tnrx_pkg::T_SB, tnrx_pkg::OPTION_TTYPE, 8'h01,
                     tnrx_pkg::T_IAC, 8'h41, tnrx_pkg::T_IAC, tnrx_pkg::T_IAC,
                     tnrx_pkg::T_SE,
                     tnrx_pkg::T_IAC, tnrx_pkg::T_DO, tnrx_pkg::OPTION_NAWS,
                     tnrx_pkg::T_IAC, tnrx_pkg::T_WILL, tnrx_pkg::OPTION_ECHO,
                     tnrx_pkg::T_IAC, tnrx_pkg::T_WONT, tnrx_pkg::OPTION_SGA,
                     tnrx_pkg::T_IAC, tnrx_pkg::T_DONT, tnrx_pkg::OPTION_TTYPE};

    repeat (12) @(negedge clk);
    rst = 1'b0;

    // part 0: reset register values, sender rarely idle, receiver mostly stalled
    foreach (directed_seq[i]) send_byte(directed_seq[i]);
    drain();

    // part 1: zero window size (defaults substituted), empty type string
    write_reg(tnrx_pkg::REG_COLUMNS, 64'd0);
    write_reg(tnrx_pkg::REG_ROWS, 64'd0);
    write_reg(tnrx_pkg::REG_TYPE_LEN, 64'd0);
    run_random(ITEMS_PER_PART);
    drain();

    // part 2: idling swapped; all-ones window size (every byte doubled),
    // over-long type length, random type string, writes past the register list
    send_gap_pct = 79;
    stall_pct    = 11;
    write_reg(tnrx_pkg::REG_COLUMNS, '1);
    write_reg(tnrx_pkg::REG_ROWS, '1);
    write_reg(tnrx_pkg::REG_TYPE_LEN, 64'h3F);
    for (int w = 0; w < NUM_TYPE_WORDS; w++)
      write_reg(tnrx_pkg::REG_TYPE_BASE + 4'(w), {$urandom, $urandom});
    write_reg(REG_UNUSED_LO, {$urandom, $urandom});
    write_reg(REG_UNUSED_HI, {$urandom, $urandom});
    run_random(ITEMS_PER_PART);
    drain();

    // part 3: no idling at all; random registers with junk in unused data bits
    send_gap_pct = 0;
    stall_pct    = 0;
    write_reg(tnrx_pkg::REG_COLUMNS, {$urandom, $urandom});
    write_reg(tnrx_pkg::REG_ROWS, {$urandom, $urandom});
    write_reg(tnrx_pkg::REG_TYPE_LEN, 64'($urandom_range(1, tnrx_pkg::TYPE_MAX_BYTES_DEF)));
    for (int w = 0; w < NUM_TYPE_WORDS; w++)
      write_reg(tnrx_pkg::REG_TYPE_BASE + 4'(w), {$urandom, $urandom});
    run_random(ITEMS_PER_PART);
    drain();

    if (mirror.due_bytes.size() != 0)
      $error("%0d expected results never arrived", mirror.due_bytes.size());
    if (mirror.mismatches == 0 && mirror.due_bytes.size() == 0) begin
      $display("telnet_rx_option_negotiator_unit regression: pass");
    end else begin
      $display("telnet_rx_option_negotiator_unit regression: fail");
    end
    $finish;
  end

endmodule
